>>> rtl/swrr_pkg.sv
// swrr_pkg: types and constants for the smooth weighted round-robin selector
// used by swrr_cell, smooth_weighted_rr_selector and its checker
`default_nettype none
package swrr_pkg;

  typedef enum logic [1:0] {
    OP_SELECT   = 2'd0,
    OP_REL_OK   = 2'd1,
    OP_REL_FAIL = 2'd2,
    OP_CONNECT  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    CFG_PEER_COUNT    = 3'd0,
    CFG_WEIGHTS       = 3'd1,
    CFG_FAIL_LIMITS   = 3'd2,
    CFG_FAIL_TIMEOUTS = 3'd3,
    CFG_CONN_LIMITS   = 3'd4,
    CFG_DOWN_MASK     = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  peer_index;
    logic [7:0]  tried_mask;
    logic [31:0] now_seconds;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [2:0]  chosen_peer;
    logic [7:0]  new_tried_mask;
    logic [10:0] round_total;
  } out_word_t;

  // per-peer configuration slice handed to a cell
  typedef struct packed {
    logic [7:0] weight;
    logic [3:0] fail_lim;
    logic [7:0] timeout;
    logic [7:0] conn_limit;
    logic       down;
  } peer_cfg_t;

  // token passed from cell to cell during a scan
  typedef struct packed {
    logic               have;
    logic [2:0]         best;
    logic signed [15:0] best_cw;
    logic [10:0]        total;
  } scan_tok_t;

  // command from the sequencer to the row
  typedef struct packed {
    logic        scan;      // scan cycle, the cell at the scan position evaluates
    logic        pick;      // apply pick to target
    logic        single;    // single peer select
    logic        release_op;
    logic        fail_op;
    logic        connect_op;
    logic [2:0]  target;
    logic [10:0] total;
    logic [7:0]  tried;
    logic [31:0] now;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/swrr_cell.sv
// swrr_cell: state of one peer; evaluates eligibility when the scan token reaches it
// depends on swrr_pkg
`default_nettype none
module swrr_cell #(
  parameter logic [2:0] IDX = 3'd0
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  swrr_pkg::peer_cfg_t  cfg,
  input  swrr_pkg::cell_cmd_t  cmd,
  input  wire                  tok_vld,   // token at this cell this cycle
  input  swrr_pkg::scan_tok_t  tok_in,
  output swrr_pkg::scan_tok_t  tok_out,   // registered token for the next cell
  output logic                 eligible_single
);

  logic signed [15:0] cw_r, cw_nxt;
  logic [7:0]  ew_r, ew_nxt;
  logic [15:0] conn_r, conn_nxt;
  logic [7:0]  fails_r, fails_nxt;
  logic [31:0] chk_r, chk_nxt;
  logic [31:0] acc_r, acc_nxt;
  swrr_pkg::scan_tok_t tok_r, tok_nxt;

  logic at_limit, fail_block, elig, me;
  logic signed [33:0] diff;
  logic signed [17:0] cw_add, cw_sub;
  logic signed [15:0] cw_inc;
  logic [7:0] dec;
  logic [16:0] recip;
  logic [24:0] prod;

  assign at_limit = (cfg.conn_limit != 8'd0) && (conn_r >= {8'd0, cfg.conn_limit});
  assign diff = $signed({2'b00, cmd.now}) - $signed({2'b00, chk_r});
  assign fail_block = (cfg.fail_lim != 4'd0) && (fails_r >= {4'd0, cfg.fail_lim})
                      && (diff <= $signed({26'd0, cfg.timeout}));
  assign elig = !cmd.tried[IDX] && !cfg.down && !fail_block && !at_limit;
  assign eligible_single = !cfg.down && !at_limit;
  assign me = (cmd.target == IDX);

  assign cw_add = {{2{cw_r[15]}}, cw_r} + $signed({10'd0, ew_r});
  assign cw_inc = (cw_add > 18'sd32767) ? 16'sh7fff : cw_add[15:0];
  assign cw_sub = {{2{cw_r[15]}}, cw_r} - $signed({7'd0, cmd.total});

  // weight drop on failure: weight / limit as weight * ceil(2^16 / limit) >> 16,
  // exact for 8-bit weights and limits up to 15
  always_comb begin
    case (cfg.fail_lim)
      4'd1:    recip = 17'd65536;
      4'd2:    recip = 17'd32768;
      4'd3:    recip = 17'd21846;
      4'd4:    recip = 17'd16384;
      4'd5:    recip = 17'd13108;
      4'd6:    recip = 17'd10923;
      4'd7:    recip = 17'd9363;
      4'd8:    recip = 17'd8192;
      4'd9:    recip = 17'd7282;
      4'd10:   recip = 17'd6554;
      4'd11:   recip = 17'd5958;
      4'd12:   recip = 17'd5462;
      4'd13:   recip = 17'd5042;
      4'd14:   recip = 17'd4682;
      4'd15:   recip = 17'd4370;
      default: recip = 17'd0;
    endcase
  end
  assign prod = {17'd0, cfg.weight} * {8'd0, recip};
  assign dec = prod[23:16];

  always_comb begin
    cw_nxt = cw_r;
    ew_nxt = ew_r;
    conn_nxt = conn_r;
    fails_nxt = fails_r;
    chk_nxt = chk_r;
    acc_nxt = acc_r;
    tok_nxt = tok_in;
    if (tok_vld && elig) begin
      cw_nxt = cw_inc;
      if (ew_r < cfg.weight) ew_nxt = ew_r + 8'd1;
      tok_nxt.total = tok_in.total + {3'd0, ew_r};
      if (!tok_in.have || cw_inc > tok_in.best_cw) begin
        tok_nxt.have = 1'b1;
        tok_nxt.best = IDX;
        tok_nxt.best_cw = cw_inc;
      end
    end
    if (me && cmd.pick) begin
      cw_nxt = (cw_sub < -18'sd32768) ? 16'sh8000 : cw_sub[15:0];
      if (diff > $signed({26'd0, cfg.timeout})) chk_nxt = cmd.now;
      if (conn_r != 16'hffff) conn_nxt = conn_r + 16'd1;
    end
    if (me && cmd.single) begin
      chk_nxt = cmd.now;
      if (conn_r != 16'hffff) conn_nxt = conn_r + 16'd1;
    end
    if (me && cmd.fail_op) begin
      if (fails_r != 8'hff) fails_nxt = fails_r + 8'd1;
      acc_nxt = cmd.now;
      chk_nxt = cmd.now;
      if (cfg.fail_lim != 4'd0) ew_nxt = (ew_r > dec) ? ew_r - dec : 8'd0;
    end
    if (me && cmd.connect_op && acc_r < chk_r) fails_nxt = 8'd0;
    if (me && cmd.release_op) begin
      if (acc_r < chk_r) fails_nxt = 8'd0;
    end
    if (me && (cmd.release_op || cmd.fail_op) && conn_r != 16'd0) conn_nxt = conn_r - 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= '0;
      ew_r <= 8'd1;
      conn_r <= '0;
      fails_r <= '0;
      chk_r <= '0;
      acc_r <= '0;
    end else begin
      cw_r <= cw_nxt;
      ew_r <= ew_nxt;
      conn_r <= conn_nxt;
      fails_r <= fails_nxt;
      chk_r <= chk_nxt;
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end
  assign tok_out = tok_r;

endmodule
`default_nettype wire

>>> rtl/smooth_weighted_rr_selector.sv
// smooth_weighted_rr_selector: top level, config registers, sequencer and a row of peer cells
// depends on swrr_pkg and swrr_cell
//
// usage: pulse start with an in_word while busy is low. a select word passes a
// scan token down the row of peer cells, one cell per cycle; each eligible peer
// adds its effective weight and the best is carried along. the chosen peer is
// then charged the round total. release and connect words touch one cell.
// a select word runs the scan state over the cells in use, then the finish state;
// other words, and a select with one peer in use, go from scan straight to done.
// busy stays high through the cycle of the result strobe.
// the scan length is set by the peer count in use: one cell per clock.
// out_valid marks the result for exactly one cycle; the receiver cannot stall.
// cfg_we writes register cfg_index from cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// reset (rst_n low, synchronous) restores the default registers, clears all
// peer state and sets effective weights to 1 (the default weight).
`default_nettype none
module smooth_weighted_rr_selector #(
  parameter int PEERS = 8
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  output logic                 busy,
  input  swrr_pkg::in_word_t   in_word,
  output logic                 out_valid,
  output swrr_pkg::out_word_t  out_word,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_index,
  input  wire  [63:0]          cfg_data
);

  localparam int CW = (PEERS > 1) ? $clog2(PEERS) : 1;

  logic [3:0]  cnt_r;
  logic [63:0] wts_r, tmo_r, lim_r;
  logic [31:0] mf_r;
  logic [7:0]  down_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd1;
      wts_r <= 64'h0101010101010101;
      mf_r <= 32'h11111111;
      tmo_r <= 64'h0A0A0A0A0A0A0A0A;
      lim_r <= '0;
      down_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        swrr_pkg::CFG_PEER_COUNT:    cnt_r <= cfg_data[3:0];
        swrr_pkg::CFG_WEIGHTS:       wts_r <= cfg_data;
        swrr_pkg::CFG_FAIL_LIMITS:   mf_r <= cfg_data[31:0];
        swrr_pkg::CFG_FAIL_TIMEOUTS: tmo_r <= cfg_data;
        swrr_pkg::CFG_CONN_LIMITS:   lim_r <= cfg_data;
        swrr_pkg::CFG_DOWN_MASK:     down_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [3:0] n_use;
  always_comb begin
    n_use = cnt_r;
    if (n_use == 4'd0) n_use = 4'd1;
    if (n_use > 4'(PEERS)) n_use = 4'(PEERS);
  end

  swrr_pkg::state_t st_r, st_nxt;
  swrr_pkg::in_word_t iw_r, iw_nxt;
  swrr_pkg::out_word_t ow_r, ow_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  swrr_pkg::cell_cmd_t cmd;
  logic ov_r, ov_nxt;

  swrr_pkg::scan_tok_t tok_o [PEERS];
  logic [PEERS-1:0] el_single;

  genvar g;
  generate
    for (g = 0; g < PEERS; g++) begin : g_cell
      swrr_pkg::peer_cfg_t pc;
      swrr_pkg::scan_tok_t ti;
      assign pc.weight = wts_r[8*g +: 8];
      assign pc.fail_lim = mf_r[4*g +: 4];
      assign pc.timeout = tmo_r[8*g +: 8];
      assign pc.conn_limit = lim_r[8*g +: 8];
      assign pc.down = down_r[g];
      if (g == 0) begin : g_head
        assign ti = '0;
      end else begin : g_link
        assign ti = tok_o[g-1];
      end
      swrr_cell #(.IDX(3'(g))) u_cell (
        .clk(clk), .rst_n(rst_n), .cfg(pc), .cmd(cmd),
        .tok_vld(cmd.scan && pos_r == CW'(g)),
        .tok_in(ti), .tok_out(tok_o[g]), .eligible_single(el_single[g])
      );
    end
  endgenerate

  // token leaving the last cell in use
  swrr_pkg::scan_tok_t tail;
  always_comb begin
    tail = '0;
    for (int k = 0; k < PEERS; k++) begin
      if (4'(k) == n_use - 4'd1) tail = tok_o[k];
    end
  end

  always_comb begin
    st_nxt = st_r;
    iw_nxt = iw_r;
    ow_nxt = ow_r;
    pos_nxt = pos_r;
    ov_nxt = 1'b0;
    cmd = '0;
    cmd.tried = iw_r.tried_mask;
    cmd.now = iw_r.now_seconds;
    cmd.target = iw_r.peer_index;
    case (st_r)
      swrr_pkg::ST_IDLE: begin
        if (start) begin
          iw_nxt = in_word;
          st_nxt = swrr_pkg::ST_SCAN;
          pos_nxt = '0;
        end
      end
      swrr_pkg::ST_SCAN: begin
        ow_nxt.found = 1'b1;
        ow_nxt.chosen_peer = iw_r.peer_index;
        ow_nxt.new_tried_mask = iw_r.tried_mask;
        ow_nxt.round_total = '0;
        if (iw_r.operation != swrr_pkg::OP_SELECT) begin
          if ({1'b0, iw_r.peer_index} < n_use) begin
            cmd.release_op = (iw_r.operation == swrr_pkg::OP_REL_OK);
            cmd.fail_op = (iw_r.operation == swrr_pkg::OP_REL_FAIL);
            cmd.connect_op = (iw_r.operation == swrr_pkg::OP_CONNECT);
          end
          st_nxt = swrr_pkg::ST_DONE;
          ov_nxt = 1'b1;
        end else if (n_use == 4'd1) begin
          ow_nxt.chosen_peer = '0;
          ow_nxt.found = el_single[0];
          cmd.target = '0;
          cmd.single = el_single[0];
          st_nxt = swrr_pkg::ST_DONE;
          ov_nxt = 1'b1;
        end else begin
          cmd.scan = 1'b1;
          if (4'(pos_r) == n_use - 4'd1) begin
            st_nxt = swrr_pkg::ST_FINISH;
          end else begin
            pos_nxt = pos_r + CW'(1);
          end
        end
      end
      swrr_pkg::ST_FINISH: begin
        ow_nxt.round_total = tail.total;
        ow_nxt.found = tail.have;
        ow_nxt.chosen_peer = tail.have ? tail.best : 3'd0;
        ow_nxt.new_tried_mask = iw_r.tried_mask | (tail.have ? (8'd1 << tail.best) : 8'd0);
        cmd.pick = tail.have;
        cmd.target = tail.best;
        cmd.total = tail.total;
        st_nxt = swrr_pkg::ST_DONE;
        ov_nxt = 1'b1;
      end
      swrr_pkg::ST_DONE: begin
        st_nxt = swrr_pkg::ST_IDLE;
      end
      default: st_nxt = swrr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= swrr_pkg::ST_IDLE;
      ov_r <= 1'b0;
      pos_r <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iw_r <= iw_nxt;
    ow_r <= ow_nxt;
  end

  // done state keeps busy high through the strobe cycle
  assign busy = (st_r != swrr_pkg::ST_IDLE);
  assign out_valid = ov_r;
  assign out_word = ow_r;

endmodule
`default_nettype wire

>>> rtl/swrr_checker.sv
// swrr_checker: port-level checks on the selector, bound to the top level
// depends on swrr_pkg
`default_nettype none
module swrr_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input wire                 out_valid,
  input swrr_pkg::out_word_t out_word
);
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than a cycle");
  a_busy_at_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("word accepted but not busy");
  a_mask_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.found && out_word.round_total != 11'd0) |->
      out_word.new_tried_mask[out_word.chosen_peer]) else $error("chosen bit missing");
endmodule

bind smooth_weighted_rr_selector swrr_checker u_swrr_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_word(out_word)
);
`default_nettype wire
